// File: src/sacia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacia_pkg
// Types and constants shared by the serial interface register block.
// ----------------------------------------------------------------------------
package sacia_pkg;

    // fifo sizes
    localparam int RX_DEPTH = 16;
    localparam int TX_DEPTH = 16;

    // pointer and fill count widths
    localparam int RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TX_PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
    localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);

    // action codes
    localparam logic [2:0] ACT_READ  = 3'd0;
    localparam logic [2:0] ACT_WRITE = 3'd1;
    localparam logic [2:0] ACT_PEEK  = 3'd2;
    localparam logic [2:0] ACT_RX    = 3'd3;
    localparam logic [2:0] ACT_TXPOP = 3'd4;

    // register addresses
    localparam logic [1:0] ADDR_DATA   = 2'd0;
    localparam logic [1:0] ADDR_STATUS = 2'd1;
    localparam logic [1:0] ADDR_CMD    = 2'd2;
    localparam logic [1:0] ADDR_CTRL   = 2'd3;

    // status and command bits
    localparam logic [7:0] ST_RXFULL       = 8'h08;
    localparam logic [7:0] ST_IRQ          = 8'h80;
    localparam logic [7:0] ST_TXEMPTY      = 8'h10;
    localparam logic [7:0] CMD_IRQ_DISABLE = 8'h02;

    // input word
    typedef struct packed {
        logic [2:0] action;
        logic [1:0] reg_addr;
        logic [7:0] bus_data;
        logic [7:0] rx_byte;
    } t_in_item;

    // result word
    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] tx_byte;
        logic       tx_pending;
        logic       irq;
        logic       dropped;
    } t_out_item;

endpackage

// File: src/serial_acia_register_model.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_acia_register_model
// Register model of a serial interface with data, status, command and
// control registers, a receive fifo and a transmit fifo in block memory.
// ----------------------------------------------------------------------------
// Usage:
//   A word on i_item is taken at a rising edge where start is high and busy
//   is low. The word is a bus read, bus write, peek, received line byte or
//   transmit pop. One result word per input word appears on o_result for
//   exactly one cycle, marked by o_valid; the receiver cannot stall it.
// Timing:
//   The fifo memories have a registered read port. The head entries are read
//   at the edge that takes the word, the next cycle does the register and
//   fifo update and writes back, and the result shows in the cycle after.
//   Busy is high for one cycle per accepted word, and no new word is taken
//   while it is high; this is set by the registered read of the fifo
//   memories ahead of the update.
// Reset:
//   i_rst_n low (synchronous) empties both fifos, sets status to transmit
//   empty, clears command and control; memory contents are not cleared and
//   need no clearing pass.
// ----------------------------------------------------------------------------
module serial_acia_register_model (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  sacia_pkg::t_in_item  i_item,
    output logic                 o_valid,
    output sacia_pkg::t_out_item o_result
);

    // fifo storage
    logic [7:0] rx_mem [sacia_pkg::RX_DEPTH];
    logic [7:0] tx_mem [sacia_pkg::TX_DEPTH];

    // control state
    logic                          r_busy;
    logic                          r_valid;
    sacia_pkg::t_in_item           r_item;
    sacia_pkg::t_out_item          r_result;
    logic [sacia_pkg::RX_PTR_W-1:0] r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [sacia_pkg::TX_PTR_W-1:0] r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic [sacia_pkg::RX_CNT_W-1:0] r_rx_count, n_rx_count;
    logic [sacia_pkg::TX_CNT_W-1:0] r_tx_count, n_tx_count;
    logic [7:0]                    r_status, n_status;
    logic [7:0]                    r_command, n_command;
    logic [7:0]                    r_control, n_control;
    logic [7:0]                    r_rx_rd, r_tx_rd;
    sacia_pkg::t_out_item          n_result;
    logic                          rx_we, tx_we;
    logic                          accept;
    logic [7:0]                    data_view;

    assign accept = start & ~r_busy;

    // registered head reads
    always_ff @(posedge i_clk) begin
        r_rx_rd <= rx_mem[r_rx_head];
        r_tx_rd <= tx_mem[r_tx_head];
    end

    // fifo write ports, only in the update cycle
    always_ff @(posedge i_clk) begin
        if (r_busy && rx_we) begin
            rx_mem[r_rx_tail] <= r_item.rx_byte;
        end
        if (r_busy && tx_we) begin
            tx_mem[r_tx_tail] <= r_item.bus_data;
        end
    end

    // data register as seen without popping
    assign data_view = (r_rx_count != '0) ? r_rx_rd : 8'h00;

    // read-modify-write of registers and fifo pointers
    always_comb begin
        n_rx_head  = r_rx_head;
        n_rx_tail  = r_rx_tail;
        n_tx_head  = r_tx_head;
        n_tx_tail  = r_tx_tail;
        n_rx_count = r_rx_count;
        n_tx_count = r_tx_count;
        n_status   = r_status;
        n_command  = r_command;
        n_control  = r_control;
        rx_we      = 1'b0;
        tx_we      = 1'b0;
        n_result   = '0;

        unique case (r_item.action)
            sacia_pkg::ACT_READ: begin
                unique case (r_item.reg_addr) inside
                    sacia_pkg::ADDR_DATA: begin
                        n_result.read_data = data_view;
                        if (r_rx_count != '0) begin
                            n_rx_head  = (r_rx_head == sacia_pkg::RX_PTR_W'(sacia_pkg::RX_DEPTH - 1))
                                       ? '0 : r_rx_head + 1'b1;
                            n_rx_count = r_rx_count - 1'b1;
                        end
                        if (n_rx_count == '0) begin
                            n_status = r_status & ~(sacia_pkg::ST_RXFULL | sacia_pkg::ST_IRQ);
                        end
                    end
                    sacia_pkg::ADDR_STATUS: begin
                        n_result.read_data = r_status;
                        n_status = r_status & ~sacia_pkg::ST_IRQ;
                    end
                    sacia_pkg::ADDR_CMD: begin
                        n_result.read_data = r_command;
                    end
                    default: begin
                        n_result.read_data = r_control;
                    end
                endcase
            end
            sacia_pkg::ACT_WRITE: begin
                unique case (r_item.reg_addr) inside
                    sacia_pkg::ADDR_DATA: begin
                        if (r_tx_count < sacia_pkg::TX_CNT_W'(sacia_pkg::TX_DEPTH)) begin
                            tx_we      = 1'b1;
                            n_tx_tail  = (r_tx_tail == sacia_pkg::TX_PTR_W'(sacia_pkg::TX_DEPTH - 1))
                                       ? '0 : r_tx_tail + 1'b1;
                            n_tx_count = r_tx_count + 1'b1;
                        end else begin
                            n_result.dropped = 1'b1;
                        end
                    end
                    sacia_pkg::ADDR_STATUS: begin
                        // soft reset
                        n_command = 8'h00;
                        n_status  = r_status & ~sacia_pkg::ST_IRQ;
                    end
                    sacia_pkg::ADDR_CMD: begin
                        n_command = r_item.bus_data;
                    end
                    default: begin
                        n_control = r_item.bus_data;
                    end
                endcase
            end
            sacia_pkg::ACT_PEEK: begin
                unique case (r_item.reg_addr) inside
                    sacia_pkg::ADDR_DATA:   n_result.read_data = data_view;
                    sacia_pkg::ADDR_STATUS: n_result.read_data = r_status;
                    sacia_pkg::ADDR_CMD:    n_result.read_data = r_command;
                    default:                n_result.read_data = r_control;
                endcase
            end
            sacia_pkg::ACT_RX: begin
                if (r_rx_count < sacia_pkg::RX_CNT_W'(sacia_pkg::RX_DEPTH)) begin
                    rx_we      = 1'b1;
                    n_rx_tail  = (r_rx_tail == sacia_pkg::RX_PTR_W'(sacia_pkg::RX_DEPTH - 1))
                               ? '0 : r_rx_tail + 1'b1;
                    n_rx_count = r_rx_count + 1'b1;
                end else begin
                    n_result.dropped = 1'b1;
                end
                n_status = r_status | sacia_pkg::ST_RXFULL | sacia_pkg::ST_IRQ;
            end
            sacia_pkg::ACT_TXPOP: begin
                if (r_tx_count != '0) begin
                    n_result.tx_byte = r_tx_rd;
                    n_tx_head  = (r_tx_head == sacia_pkg::TX_PTR_W'(sacia_pkg::TX_DEPTH - 1))
                               ? '0 : r_tx_head + 1'b1;
                    n_tx_count = r_tx_count - 1'b1;
                end
            end
            default: begin
            end
        endcase

        // flags after the update
        n_result.tx_pending = (n_tx_count != '0);
        n_result.irq        = ((n_status & sacia_pkg::ST_IRQ) != 8'h00)
                            && ((n_command & sacia_pkg::CMD_IRQ_DISABLE) == 8'h00);
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_valid    <= 1'b0;
            r_rx_head  <= '0;
            r_rx_tail  <= '0;
            r_tx_head  <= '0;
            r_tx_tail  <= '0;
            r_rx_count <= '0;
            r_tx_count <= '0;
            r_status   <= sacia_pkg::ST_TXEMPTY;
            r_command  <= 8'h00;
            r_control  <= 8'h00;
        end else begin
            r_valid <= r_busy;
            if (accept) begin
                r_busy <= 1'b1;
                r_item <= i_item;
            end else if (r_busy) begin
                r_busy     <= 1'b0;
                r_result   <= n_result;
                r_rx_head  <= n_rx_head;
                r_rx_tail  <= n_rx_tail;
                r_tx_head  <= n_tx_head;
                r_tx_tail  <= n_tx_tail;
                r_rx_count <= n_rx_count;
                r_tx_count <= n_tx_count;
                r_status   <= n_status;
                r_command  <= n_command;
                r_control  <= n_control;
            end
        end
    end

    assign busy     = r_busy;
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
